[hdl/hashed_lru_block_buffer_cache_macros.svh]
`ifndef HASHED_LRU_BLOCK_BUFFER_CACHE_MACROS_SVH
`define HASHED_LRU_BLOCK_BUFFER_CACHE_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define HLBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hlbc assertion failed");

// next-cycle implication
`define HLBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hlbc assertion failed");

`endif

[hdl/hlbc_pkg.sv]
package hlbc_pkg;

  localparam int SLOT_COUNT_DEF   = 32;
  localparam int BUCKET_COUNT_DEF = 13;

  localparam int BLOCK_W  = 32;
  localparam int DIGIT_W  = 4;
  localparam int DIGITS   = BLOCK_W / DIGIT_W;
  localparam int SLOT_W   = 5;
  localparam int DEV_W    = 8;
  localparam int CNT_W    = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

endpackage

[hdl/hashed_lru_block_buffer_cache.sv]
// Buffer cache tag manager. One command is taken at a time; in_stall_o stays high
// from the transfer until the result is loaded into the output register. Release,
// pin and unpin update the slot count in S_SLOTOP; a release that drops it to zero also
// moves the slot to its bucket head through S_UNL_P, S_UNL_N, S_PUSH1 and S_PUSH2. A get
// first hashes the block number (a 4-bit-per-cycle residue unit), then walks its
// bucket list one slot per cycle for the tag match, then walks bucket tails one
// slot per cycle for a free slot, own bucket first; a slot taken from another bucket
// is relinked to its new bucket head by those states. Reset values are loaded at once.
module hashed_lru_block_buffer_cache
  import hlbc_pkg::*;
#(
  parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
  parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [DEV_W-1:0]   device_i,
  input  logic [BLOCK_W-1:0] block_number_i,
  input  logic [SLOT_W-1:0]  slot_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SLOT_W-1:0]  slot_out_o,
  output logic               hit_o,
  output logic               need_read_o,
  output logic [1:0]         status_o
);

  localparam int SW  = $clog2(SLOT_COUNT + 1);
  localparam int IW  = $clog2(SLOT_COUNT);
  localparam int BIW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int BW  = $clog2(BUCKET_COUNT + 2);
  localparam logic [SW-1:0] NONE = SW'(SLOT_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_SEARCH, S_FREE, S_UNL_P, S_UNL_N,
    S_PUSH1, S_PUSH2, S_SLOTOP, S_DONE
  } state_e;

  state_e              state_q;
  cmd_e                cmd_q;
  logic [DEV_W-1:0]    dev_q;
  logic [BLOCK_W-1:0]  blk_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [BIW-1:0]      b_q;
  logic [BW-1:0]       fb_q;
  logic                own_q;
  logic [SW-1:0]       ptr_q;
  logic [SW-1:0]       f_q;
  logic [BIW-1:0]      mb_q;
  logic [SLOT_W-1:0]   so_q;
  logic                hit_q, nr_q;
  status_e             st_q;

  logic                out_valid_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic                out_hit_q, out_nr_q;
  status_e             out_st_q;

  logic [DEV_W-1:0]    tag_dev_q   [SLOT_COUNT];
  logic [BLOCK_W-1:0]  tag_blk_q   [SLOT_COUNT];
  logic                cvalid_q    [SLOT_COUNT];
  logic [CNT_W-1:0]    count_q     [SLOT_COUNT];
  logic [BIW-1:0]      bucket_q    [SLOT_COUNT];
  logic [SW-1:0]       next_q      [SLOT_COUNT];
  logic [SW-1:0]       prev_q      [SLOT_COUNT];
  logic [SW-1:0]       head_q      [BUCKET_COUNT];
  logic [SW-1:0]       tail_q      [BUCKET_COUNT];

  logic                mod_start;
  logic                mod_done;
  logic [BIW-1:0]      mod_res;

  logic                accept;
  logic [IW-1:0]       pi, fi, si;
  logic [BW-1:0]       nb;
  logic [SW-1:0]       fp, fn;
  logic                slot_oor;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign mod_start  = accept && (cmd_e'(command_i) == CMD_GET);

  assign pi       = ptr_q[IW-1:0];
  assign fi       = f_q[IW-1:0];
  assign si       = IW'(slot_q);
  assign fp       = prev_q[fi];
  assign fn       = next_q[fi];
  assign slot_oor = (32'(slot_q) >= 32'(SLOT_COUNT));

  always_comb begin
    nb = own_q ? '0 : fb_q + 1'b1;
    if (nb == BW'(b_q)) begin
      nb = nb + 1'b1;
    end
  end

  hlbc_mod_unit #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .BIW          (BIW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .value_i   (block_number_i),
    .done_o    (mod_done),
    .residue_o (mod_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_GET;
      st_q        <= ST_OK;
      out_st_q    <= ST_OK;
      own_q       <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tag_dev_q[i] <= '0;
        tag_blk_q[i] <= '0;
        cvalid_q[i]  <= 1'b0;
        count_q[i]   <= '0;
        bucket_q[i]  <= BIW'(i % BUCKET_COUNT);
        next_q[i]    <= (i >= BUCKET_COUNT) ? SW'(i - BUCKET_COUNT) : NONE;
        prev_q[i]    <= (i + BUCKET_COUNT < SLOT_COUNT) ? SW'(i + BUCKET_COUNT) : NONE;
      end
      for (int j = 0; j < BUCKET_COUNT; j++) begin
        head_q[j] <= (j < SLOT_COUNT) ?
                     SW'(j + BUCKET_COUNT * ((SLOT_COUNT - 1 - j) / BUCKET_COUNT)) : NONE;
        tail_q[j] <= (j < SLOT_COUNT) ? SW'(j) : NONE;
      end
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q  <= cmd_e'(command_i);
            dev_q  <= device_i;
            blk_q  <= block_number_i;
            slot_q <= slot_i;
            state_q <= (cmd_e'(command_i) == CMD_GET) ? S_HASH : S_SLOTOP;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            b_q     <= mod_res;
            ptr_q   <= head_q[mod_res];
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (ptr_q == NONE) begin
            fb_q    <= BW'(b_q);
            own_q   <= 1'b1;
            ptr_q   <= tail_q[b_q];
            state_q <= S_FREE;
          end else if (tag_dev_q[pi] == dev_q && tag_blk_q[pi] == blk_q) begin
            hit_q <= 1'b1;
            nr_q  <= !cvalid_q[pi];
            so_q  <= SLOT_W'(ptr_q);
            st_q  <= ST_OK;
            cvalid_q[pi] <= 1'b1;
            if (count_q[pi] != CNT_MAX) begin
              count_q[pi] <= count_q[pi] + 1'b1;
            end
            state_q <= S_DONE;
          end else begin
            ptr_q <= next_q[pi];
          end
        end
        S_FREE: begin
          if (ptr_q == NONE) begin
            own_q <= 1'b0;
            if (nb >= BW'(BUCKET_COUNT)) begin
              hit_q   <= 1'b0;
              nr_q    <= 1'b0;
              so_q    <= slot_q;
              st_q    <= ST_NO_FREE;
              state_q <= S_DONE;
            end else begin
              fb_q  <= nb;
              ptr_q <= tail_q[nb[BIW-1:0]];
            end
          end else if (count_q[pi] == '0) begin
            tag_dev_q[pi] <= dev_q;
            tag_blk_q[pi] <= blk_q;
            count_q[pi]   <= CNT_W'(1);
            cvalid_q[pi]  <= 1'b1;
            hit_q <= 1'b0;
            nr_q  <= 1'b1;
            so_q  <= SLOT_W'(ptr_q);
            st_q  <= ST_OK;
            if (own_q) begin
              state_q <= S_DONE;
            end else begin
              f_q     <= ptr_q;
              mb_q    <= fb_q[BIW-1:0];
              state_q <= S_UNL_P;
            end
          end else begin
            ptr_q <= prev_q[pi];
          end
        end
        S_UNL_P: begin
          if (fp == NONE) begin
            head_q[mb_q] <= fn;
          end else begin
            next_q[fp[IW-1:0]] <= fn;
          end
          state_q <= S_UNL_N;
        end
        S_UNL_N: begin
          if (fn == NONE) begin
            tail_q[mb_q] <= fp;
          end else begin
            prev_q[fn[IW-1:0]] <= fp;
          end
          state_q <= S_PUSH1;
        end
        S_PUSH1: begin
          next_q[fi]   <= head_q[b_q];
          prev_q[fi]   <= NONE;
          bucket_q[fi] <= b_q;
          state_q      <= S_PUSH2;
        end
        S_PUSH2: begin
          if (fn == NONE) begin
            tail_q[b_q] <= f_q;
          end else begin
            prev_q[fn[IW-1:0]] <= f_q;
          end
          head_q[b_q] <= f_q;
          state_q     <= S_DONE;
        end
        S_SLOTOP: begin
          hit_q   <= 1'b0;
          nr_q    <= 1'b0;
          so_q    <= slot_q;
          st_q    <= ST_OK;
          state_q <= S_DONE;
          if (!slot_oor) begin
            if (cmd_q == CMD_PIN) begin
              if (count_q[si] != CNT_MAX) begin
                count_q[si] <= count_q[si] + 1'b1;
              end
            end else if (count_q[si] == '0) begin
              st_q <= ST_UNDERFLOW;
            end else begin
              count_q[si] <= count_q[si] - 1'b1;
              if (cmd_q == CMD_RELEASE && count_q[si] == CNT_W'(1)) begin
                f_q     <= SW'(si);
                mb_q    <= bucket_q[si];
                b_q     <= bucket_q[si];
                state_q <= S_UNL_P;
              end
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_slot_q  <= so_q;
            out_hit_q   <= hit_q;
            out_nr_q    <= nr_q;
            out_st_q    <= st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_out_o  = out_slot_q;
  assign hit_o       = out_hit_q;
  assign need_read_o = out_nr_q;
  assign status_o    = out_st_q;

endmodule

[hdl/hlbc_mod_unit.sv]
module hlbc_mod_unit
  import hlbc_pkg::*;
#(
  parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
  parameter int BIW          = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [BLOCK_W-1:0] value_i,
  output logic               done_o,
  output logic [BIW-1:0]     residue_o
);

  localparam int VW = BIW + DIGIT_W + 1;
  localparam int CW = $clog2(DIGITS + 1);

  localparam logic [VW-1:0] B1 = VW'(BUCKET_COUNT);
  localparam logic [VW-1:0] B2 = VW'(BUCKET_COUNT * 2);
  localparam logic [VW-1:0] B4 = VW'(BUCKET_COUNT * 4);
  localparam logic [VW-1:0] B8 = VW'(BUCKET_COUNT * 8);

  logic [CW-1:0]      cnt_q;
  logic [BLOCK_W-1:0] sh_q;
  logic [BIW-1:0]     r_q;
  logic               busy_q;
  logic               done_q;
  logic [VW-1:0]      v0, v1, v2, v3, v4;

  always_comb begin
    v0 = {1'b0, r_q, sh_q[BLOCK_W-1 -: DIGIT_W]};
    v1 = (v0 >= B8) ? v0 - B8 : v0;
    v2 = (v1 >= B4) ? v1 - B4 : v1;
    v3 = (v2 >= B2) ? v2 - B2 : v2;
    v4 = (v3 >= B1) ? v3 - B1 : v3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      r_q    <= '0;
      sh_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        r_q    <= '0;
        sh_q   <= value_i;
      end else if (busy_q) begin
        r_q  <= v4[BIW-1:0];
        sh_q <= sh_q << DIGIT_W;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIGITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o    = done_q;
  assign residue_o = r_q;

endmodule

[hdl/hlbc_checker.sv]
`include "hashed_lru_block_buffer_cache_macros.svh"

module hlbc_checker
  import hlbc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [SLOT_W-1:0]  slot_out_o,
  input logic               hit_o,
  input logic               need_read_o,
  input logic [1:0]         status_o
);

  logic [SLOT_W+3:0] out_word;

  assign out_word = {slot_out_o, hit_o, need_read_o, status_o};

  `HLBC_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && !in_stall_o, in_stall_o)
  `HLBC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word))
  `HLBC_ASSERT_NOW(a_hit_ok, out_valid_o && hit_o, status_o == ST_OK)
  `HLBC_ASSERT_NOW(a_nofree_flags, out_valid_o && status_o == ST_NO_FREE, !hit_o && !need_read_o)
  `HLBC_ASSERT_NOW(a_status_code, out_valid_o, status_o != 2'd3)

endmodule

bind hashed_lru_block_buffer_cache hlbc_checker u_hlbc_checker (.*);
